FILE: rtl/core/gcc_pkg.sv
// Shared types and constants for the graph connectivity checker.
// Used by the top level, the search sequencer and the checker; depends on nothing else.
package gcc_pkg;

    localparam int GCC_MAX_NODES    = 32;
    localparam int ROW_W            = 32;
    localparam int ROW_INDEX_W      = 5;
    localparam int NODE_COUNT_W     = 6;
    localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 6'd20;

    // One adjacency row request.
    typedef struct packed {
        logic [ROW_INDEX_W-1:0]  row_index;
        logic [ROW_W-1:0]        row_bits;
        logic                    last_row;
    } gcc_row_t;

    // One connectivity result.
    typedef struct packed {
        logic                    connected;
        logic [NODE_COUNT_W-1:0] reached_count;
    } gcc_result_t;

    // Control from the top level to the search sequencer.
    typedef struct packed {
        logic                    start;
        logic [NODE_COUNT_W-1:0] node_count;
    } gcc_walk_ctl_t;

    // Status from the search sequencer back to the top level.
    typedef struct packed {
        logic                    busy;
        logic                    done;
        logic                    connected;
        logic [NODE_COUNT_W-1:0] reached_count;
    } gcc_walk_stat_t;

endpackage

FILE: rtl/core/graph_connectivity_check.sv
// After the last-row request is accepted, the search sweeps the stored rows
// up to the clamped node count until a pass adds no node, then gives the result.
// Throughput: one row request per cycle while loading, unless a result is stalled
// in the output register; no request is taken during the search.
// Reset (rst_n, asynchronous, active low) clears control state and the reached
// mask and sets node_count to 20; stored rows stay undefined until written.
module graph_connectivity_check import gcc_pkg::*; #(
    parameter int MAX_NODES = GCC_MAX_NODES
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [NODE_COUNT_W-1:0] cfg_wdata,
    input  logic                    row_valid,
    output logic                    row_ready,
    input  gcc_row_t                row,
    output logic                    result_valid,
    input  logic                    result_ready,
    output gcc_result_t             result
);

    localparam int AW = $clog2(MAX_NODES);

    logic [NODE_COUNT_W-1:0] node_count_reg;
    logic                    result_valid_reg;
    gcc_result_t             result_reg;

    logic                    row_accept;
    logic                    row_in_range;
    logic [AW-1:0]           rd_addr;
    logic [ROW_W-1:0]        rd_data;
    gcc_walk_ctl_t           walk_ctl;
    gcc_walk_stat_t          walk_stat;

    // A request is taken only when the search is idle and the output register
    // is free or being emptied in this cycle, so a finished result never
    // collides with a waiting one.
    assign row_ready    = !walk_stat.busy && !walk_stat.done
                          && (!result_valid_reg || result_ready);
    assign row_accept   = row_valid && row_ready;

    // Rows whose index lies beyond the built store are dropped.
    assign row_in_range = (32'(row.row_index) < 32'(MAX_NODES));

    // The adjacency rows live in a RAM: written by incoming requests, read one
    // row per cycle by the search sequencer.
    gcc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_NODES)
    ) u_adj_ram (
        .clk   (clk),
        .we    (row_accept && row_in_range),
        .waddr (AW'(row.row_index)),
        .wdata (row.row_bits),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // The last row is written at the same edge that starts the search; the
    // first read is issued at the following edge and so sees it.
    assign walk_ctl.start      = row_accept && row.last_row;
    assign walk_ctl.node_count = node_count_reg;

    gcc_walk #(
        .MAX_NODES (MAX_NODES)
    ) u_walk (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (walk_ctl),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .stat    (walk_stat)
    );

    // Configuration register and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg   <= NODE_COUNT_RESET;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
            if (walk_stat.done)
            begin
                result_valid_reg         <= 1'b1;
                result_reg.connected     <= walk_stat.connected;
                result_reg.reached_count <= walk_stat.reached_count;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: rtl/core/gcc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the adjacency rows of the checker.
module gcc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/gcc_walk.sv
// Reachability sequencer: repeated passes over the stored rows with one shared
// OR/compare unit until the reached mask settles. Depends on gcc_pkg.
module gcc_walk import gcc_pkg::*; #(
    parameter int MAX_NODES = GCC_MAX_NODES,
    localparam int AW = $clog2(MAX_NODES)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  gcc_walk_ctl_t    ctl,
    output logic [AW-1:0]    rd_addr,
    input  logic [ROW_W-1:0] rd_data,
    output gcc_walk_stat_t   stat
);

    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int XW = (CW > NODE_COUNT_W) ? CW : NODE_COUNT_W;
    localparam int SW = CW + 1;

    typedef enum logic [1:0] {
        W_IDLE,
        W_SCAN,
        W_FINISH
    } walk_state_t;

    walk_state_t            state_reg;
    logic [CW-1:0]          n_reg;
    logic [MAX_NODES-1:0]   nmask_reg;
    logic [MAX_NODES-1:0]   mask_reg;
    logic [AW-1:0]          ptr_reg;
    logic [AW-1:0]          pend_idx_reg;
    logic                   pend_valid_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   changed_reg;
    logic                   done_reg;
    logic                   conn_reg;
    logic [NODE_COUNT_W-1:0] count_reg;

    logic [XW-1:0]          nc_ext;
    logic [CW-1:0]          n_start;
    logic [MAX_NODES-1:0]   nmask_start;
    logic                   hit;
    logic [MAX_NODES-1:0]   grown;
    logic [MAX_NODES-1:0]   mask_next;
    logic [CW-1:0]          cnt_next;
    logic                   changed_next;
    logic                   last_ptr;

    // Clamp the configured node count into 1 .. MAX_NODES and build its mask.
    always_comb
    begin
        nc_ext = XW'(ctl.node_count);
        if (nc_ext == '0)
        begin
            n_start = CW'(1);
        end
        else if (nc_ext > XW'(MAX_NODES))
        begin
            n_start = CW'(MAX_NODES);
        end
        else
        begin
            n_start = CW'(nc_ext);
        end
        for (int i = 0; i < MAX_NODES; i++)
        begin
            nmask_start[i] = (SW'(i) < SW'(n_start));
        end
    end

    // Shared unit: fold the row read last cycle into the mask when its node
    // is reached, and count reached nodes seen during this pass.
    always_comb
    begin
        hit          = pend_valid_reg && mask_reg[pend_idx_reg];
        grown        = mask_reg | (MAX_NODES'(rd_data) & nmask_reg);
        mask_next    = hit ? grown : mask_reg;
        changed_next = changed_reg || (hit && (grown != mask_reg));
        cnt_next     = cnt_reg + CW'(hit);
        last_ptr     = (SW'(ptr_reg) + SW'(1)) == SW'(n_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= W_IDLE;
            n_reg          <= CW'(1);
            nmask_reg      <= '0;
            mask_reg       <= '0;
            ptr_reg        <= '0;
            pend_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            changed_reg    <= 1'b0;
            cnt_reg        <= '0;
            done_reg       <= 1'b0;
            conn_reg       <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                W_IDLE:
                begin
                    if (ctl.start)
                    begin
                        n_reg          <= n_start;
                        nmask_reg      <= nmask_start;
                        mask_reg       <= MAX_NODES'(1);
                        ptr_reg        <= '0;
                        cnt_reg        <= '0;
                        changed_reg    <= 1'b0;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= W_SCAN;
                    end
                end
                W_SCAN:
                begin
                    mask_reg       <= mask_next;
                    cnt_reg        <= cnt_next;
                    changed_reg    <= changed_next;
                    pend_valid_reg <= 1'b1;
                    pend_idx_reg   <= ptr_reg;
                    if (last_ptr)
                    begin
                        state_reg <= W_FINISH;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + AW'(1);
                    end
                end
                W_FINISH:
                begin
                    mask_reg       <= mask_next;
                    pend_valid_reg <= 1'b0;
                    if (changed_next)
                    begin
                        // The mask grew during this pass, so sweep again.
                        ptr_reg     <= '0;
                        cnt_reg     <= '0;
                        changed_reg <= 1'b0;
                        state_reg   <= W_SCAN;
                    end
                    else
                    begin
                        // A pass with no growth counted the final reached set.
                        done_reg  <= 1'b1;
                        conn_reg  <= (cnt_next == n_reg);
                        count_reg <= NODE_COUNT_W'(cnt_next);
                        state_reg <= W_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= W_IDLE;
                end
            endcase
        end
    end

    assign rd_addr            = ptr_reg;
    assign stat.busy          = (state_reg != W_IDLE);
    assign stat.done          = done_reg;
    assign stat.connected     = conn_reg;
    assign stat.reached_count = count_reg;

endmodule

FILE: rtl/core/gcc_checker.sv
// Port-level checks for the graph connectivity checker, bound to the top level.
// Depends on gcc_pkg and on graph_connectivity_check.
module gcc_checker import gcc_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        row_valid,
    input logic        row_ready,
    input gcc_row_t    row,
    input logic        result_valid,
    input logic        result_ready,
    input gcc_result_t result
);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

    // A result never appears right after a request; the search takes longer.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !$past(row_valid && row_ready))
    else $error("result appeared right after a request");

    // Taking the last row deasserts row_ready; later cycles of the search are not checked here.
    assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && row_ready && row.last_row |=> !row_ready)
    else $error("request taken right after the last row");

    // While a result waits, no new request is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |-> !row_ready)
    else $error("request taken while a result is stalled");

    // Node 0 is always reached.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.reached_count != '0)
    else $error("result reports no reached node");

endmodule

bind graph_connectivity_check gcc_checker u_gcc_checker (.*);
